// ===== design/zrbc_pkg.sv =====
`timescale 1ns / 1ps

package zrbc_pkg;

  // Longest run of zero or literal bytes in one part
  localparam int unsigned MaxRun    = 8;
  localparam int unsigned RunCntW   = $clog2(MaxRun + 1);
  localparam int unsigned LenW      = 3;

  // Literal buffer: two parts of literals at most
  localparam int unsigned LitDepth  = 16;
  localparam int unsigned LitIdxW   = $clog2(LitDepth);
  localparam int unsigned LitCntW   = $clog2(LitDepth + 1);

  // Group queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Result item kinds
  localparam logic KindOpcode  = 1'b0;
  localparam logic KindLiteral = 1'b1;

  typedef logic [7:0] lit_byte_t;

  // One closed group, ready to be sent out
  typedef struct packed {
    logic                              first_zero;
    logic [LenW-1:0]                   first_len;
    logic                              second_zero;
    logic [LenW-1:0]                   second_len;
    logic [LitCntW-1:0]                lit_cnt;
    logic [LitDepth-1:0][7:0]          lits;
    logic                              last_grp;
  } group_t;

  // One result item
  typedef struct packed {
    logic            kind;
    lit_byte_t       lit;
    logic            first_zero;
    logic [LenW-1:0] first_len;
    logic            second_zero;
    logic [LenW-1:0] second_len;
    logic            last_item;
  } item_t;

  // Zero run: count-1; literal run: (8-count) mod 8
  function automatic logic [LenW-1:0] len_code(input logic zero,
                                               input logic [RunCntW-1:0] count);
    logic [3:0] cnt4;
    cnt4 = 4'(count);
    if (zero) begin
      return LenW'(cnt4 - 4'd1);
    end else begin
      return LenW'(4'd8 - cnt4);
    end
  endfunction

endpackage

// ===== design/zrbc_in_if.sv =====
`timescale 1ns / 1ps

interface zrbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/zrbc_out_if.sv =====
`timescale 1ns / 1ps

interface zrbc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] literal_value;
  logic       first_zero_run;
  logic [2:0] first_length;
  logic       second_zero_run;
  logic [2:0] second_length;
  logic       final_item;

  modport source (output valid, output item_kind, output literal_value,
                  output first_zero_run, output first_length,
                  output second_zero_run, output second_length,
                  output final_item, input ready);
  modport sink   (input valid, input item_kind, input literal_value,
                  input first_zero_run, input first_length,
                  input second_zero_run, input second_length,
                  input final_item, output ready);
endinterface

// ===== design/zrbc_fifo.sv =====
`timescale 1ns / 1ps

module zrbc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  zrbc_pkg::group_t push_data_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output zrbc_pkg::group_t pop_data_o,
  input  logic            pop_ready_i
);

  zrbc_pkg::group_t                    mem_q [zrbc_pkg::FifoDepth];
  logic [zrbc_pkg::FifoPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [zrbc_pkg::FifoPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [zrbc_pkg::FifoCntW-1:0]       cnt_q, cnt_d;
  logic                                push, pop;

  assign push_ready_o = (cnt_q != zrbc_pkg::FifoCntW'(zrbc_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == zrbc_pkg::FifoPtrW'(zrbc_pkg::FifoDepth - 1)) ?
                 '0 : wr_ptr_q + zrbc_pkg::FifoPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == zrbc_pkg::FifoPtrW'(zrbc_pkg::FifoDepth - 1)) ?
                 '0 : rd_ptr_q + zrbc_pkg::FifoPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + zrbc_pkg::FifoCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - zrbc_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed group
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/zrbc_front.sv =====
`timescale 1ns / 1ps

module zrbc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  zrbc_in_if.sink          in_i,
  output logic             push_valid_o,
  output zrbc_pkg::group_t push_data_o,
  input  logic             push_ready_i
);

  logic                                    group_open_q, group_open_d;
  logic                                    in_second_q, in_second_d;
  logic                                    run_zero_q, run_zero_d;
  logic [zrbc_pkg::RunCntW-1:0]            run_cnt_q, run_cnt_d;
  logic                                    saved_fz_q, saved_fz_d;
  logic [zrbc_pkg::LenW-1:0]               saved_fl_q, saved_fl_d;
  logic [zrbc_pkg::LitCntW-1:0]            lit_cnt_q, lit_cnt_d;
  logic [zrbc_pkg::LitDepth-1:0][7:0]      lit_q, lit_d;
  logic                                    pend_valid_q, pend_valid_d;
  zrbc_pkg::group_t                        pend_q;

  zrbc_pkg::group_t                        early_grp, late_grp;
  logic                                    early_v, late_v;
  logic                                    accept;

  // Hold input while a second group of the same byte waits or the group queue is full
  assign in_i.ready = !pend_valid_q && push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the byte and close parts and groups
  always_comb begin
    logic                     z;
    logic [zrbc_pkg::LenW-1:0] code;

    z            = (in_i.data_byte == 8'h00);
    group_open_d = group_open_q;
    in_second_d  = in_second_q;
    run_zero_d   = run_zero_q;
    run_cnt_d    = run_cnt_q;
    saved_fz_d   = saved_fz_q;
    saved_fl_d   = saved_fl_q;
    lit_cnt_d    = lit_cnt_q;
    lit_d        = lit_q;
    early_v      = 1'b0;
    late_v       = 1'b0;
    early_grp    = '0;
    late_grp     = '0;
    code         = '0;

    // Zero-ness change closes the open part
    if (group_open_d && run_cnt_d != '0 && run_zero_d != z) begin
      code = zrbc_pkg::len_code(run_zero_d, run_cnt_d);
      if (!in_second_d) begin
        saved_fz_d  = run_zero_d;
        saved_fl_d  = code;
        in_second_d = 1'b1;
        run_cnt_d   = '0;
      end else begin
        early_v               = 1'b1;
        early_grp.first_zero  = saved_fz_d;
        early_grp.first_len   = saved_fl_d;
        early_grp.second_zero = run_zero_d;
        early_grp.second_len  = code;
        early_grp.lit_cnt     = lit_cnt_d;
        early_grp.lits        = lit_q;
        early_grp.last_grp    = 1'b0;
        group_open_d          = 1'b0;
        in_second_d           = 1'b0;
        run_cnt_d             = '0;
        lit_cnt_d             = '0;
      end
    end

    // Extend the part or open a new one
    if (group_open_d && run_cnt_d != '0) begin
      run_cnt_d = run_cnt_d + zrbc_pkg::RunCntW'(1);
    end else begin
      if (!group_open_d) begin
        group_open_d = 1'b1;
        in_second_d  = 1'b0;
        lit_cnt_d    = '0;
      end
      run_zero_d = z;
      run_cnt_d  = zrbc_pkg::RunCntW'(1);
    end

    // Buffer a nonzero byte
    if (!z && lit_cnt_d < zrbc_pkg::LitCntW'(zrbc_pkg::LitDepth)) begin
      lit_d[lit_cnt_d[zrbc_pkg::LitIdxW-1:0]] = in_i.data_byte;
      lit_cnt_d = lit_cnt_d + zrbc_pkg::LitCntW'(1);
    end

    // Full part closes at once
    if (run_cnt_d >= zrbc_pkg::RunCntW'(zrbc_pkg::MaxRun)) begin
      code = zrbc_pkg::len_code(run_zero_d, run_cnt_d);
      if (!in_second_d) begin
        saved_fz_d  = run_zero_d;
        saved_fl_d  = code;
        in_second_d = 1'b1;
        run_cnt_d   = '0;
      end else begin
        late_v               = 1'b1;
        late_grp.first_zero  = saved_fz_d;
        late_grp.first_len   = saved_fl_d;
        late_grp.second_zero = run_zero_d;
        late_grp.second_len  = code;
        late_grp.lit_cnt     = lit_cnt_d;
        late_grp.lits        = lit_d;
        late_grp.last_grp    = in_i.last_byte;
        group_open_d         = 1'b0;
        in_second_d          = 1'b0;
        run_cnt_d            = '0;
        lit_cnt_d            = '0;
      end
    end

    // End of stream flushes the open group
    if (in_i.last_byte && group_open_d) begin
      late_v            = 1'b1;
      late_grp.lit_cnt  = lit_cnt_d;
      late_grp.lits     = lit_d;
      late_grp.last_grp = 1'b1;
      if (run_cnt_d != '0 && in_second_d) begin
        late_grp.first_zero  = saved_fz_d;
        late_grp.first_len   = saved_fl_d;
        late_grp.second_zero = run_zero_d;
        late_grp.second_len  = zrbc_pkg::len_code(run_zero_d, run_cnt_d);
      end else begin
        if (run_cnt_d != '0) begin
          saved_fz_d = run_zero_d;
          saved_fl_d = zrbc_pkg::len_code(run_zero_d, run_cnt_d);
        end
        late_grp.first_zero  = saved_fz_d;
        late_grp.first_len   = saved_fl_d;
        late_grp.second_zero = 1'b1;
        late_grp.second_len  = '0;
      end
      group_open_d = 1'b0;
      in_second_d  = 1'b0;
      run_cnt_d    = '0;
      lit_cnt_d    = '0;
    end
  end

  // Push pending group first, else the earlier group of this byte
  assign push_valid_o = pend_valid_q || (accept && (early_v || late_v));
  assign push_data_o  = pend_valid_q ? pend_q : (early_v ? early_grp : late_grp);

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (pend_valid_q && push_ready_i) begin
      pend_valid_d = 1'b0;
    end else if (accept && early_v && late_v) begin
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_open_q <= 1'b0;
      in_second_q  <= 1'b0;
      run_zero_q   <= 1'b0;
      run_cnt_q    <= '0;
      saved_fz_q   <= 1'b0;
      saved_fl_q   <= '0;
      lit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        group_open_q <= group_open_d;
        in_second_q  <= in_second_d;
        run_zero_q   <= run_zero_d;
        run_cnt_q    <= run_cnt_d;
        saved_fz_q   <= saved_fz_d;
        saved_fl_q   <= saved_fl_d;
        lit_cnt_q    <= lit_cnt_d;
      end
    end
  end

  // Literal buffer and pending group payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lit_q <= lit_d;
      if (early_v && late_v) begin
        pend_q <= late_grp;
      end
    end
  end

endmodule

// ===== design/zrbc_back.sv =====
`timescale 1ns / 1ps

module zrbc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  zrbc_pkg::group_t pop_data_i,
  output logic             pop_ready_o,
  zrbc_out_if.source       out_o
);

  zrbc_pkg::group_t               cur_q;
  logic                           cur_valid_q;
  logic [zrbc_pkg::LitCntW-1:0]   idx_q;
  zrbc_pkg::item_t                out_q, item;
  logic                           out_valid_q;
  logic                           advance, at_end, take;

  assign advance     = cur_valid_q && (!out_valid_q || out_o.ready);
  assign at_end      = (idx_q == cur_q.lit_cnt);
  assign take        = !cur_valid_q || (advance && at_end);
  assign pop_ready_o = take;

  // Build the item at the current index: opcode first, then literals
  always_comb begin
    item           = '0;
    item.last_item = cur_q.last_grp && at_end;
    if (idx_q == '0) begin
      item.kind        = zrbc_pkg::KindOpcode;
      item.first_zero  = cur_q.first_zero;
      item.first_len   = cur_q.first_len;
      item.second_zero = cur_q.second_zero;
      item.second_len  = cur_q.second_len;
    end else begin
      item.kind = zrbc_pkg::KindLiteral;
      item.lit  = cur_q.lits[zrbc_pkg::LitIdxW'(idx_q - zrbc_pkg::LitCntW'(1))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      // Drain output register
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // Step through the group, load the next one at its end
      if (take) begin
        cur_valid_q <= pop_valid_i;
        idx_q       <= '0;
      end else if (advance) begin
        idx_q <= idx_q + zrbc_pkg::LitCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= item;
    end
    if (take && pop_valid_i) begin
      cur_q <= pop_data_i;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.item_kind       = out_q.kind;
  assign out_o.literal_value   = out_q.lit;
  assign out_o.first_zero_run  = out_q.first_zero;
  assign out_o.first_length    = out_q.first_len;
  assign out_o.second_zero_run = out_q.second_zero;
  assign out_o.second_length   = out_q.second_len;
  assign out_o.final_item      = out_q.last_item;

endmodule

// ===== design/zero_run_byte_compressor_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                                        Transaction
// in_i     in   data_byte, last_byte                           one raw byte
// out_o    out  item_kind, literal_value, first/second fields, one opcode or
//               final_item                                     literal item
//
// Input takes one byte per cycle while the two-entry group queue has room.
// A byte that ends one group and also ends the stream holds input until its
// second group is pushed. Output sends one item per cycle while out_o is ready:
// an opcode and up to 16 literals per group, back to back across groups.
// Reset clears all control state; the literal buffer needs no clearing.
module zero_run_byte_compressor_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  zrbc_in_if.sink    in_i,
  zrbc_out_if.source out_o
);

  logic             push_valid, push_ready;
  zrbc_pkg::group_t push_data;
  logic             pop_valid, pop_ready;
  zrbc_pkg::group_t pop_data;

  zrbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  zrbc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  zrbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// ===== tb/zrbc_checker.sv =====
`timescale 1ns / 1ps

module zrbc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  zrbc_in_if          in_mon,
  zrbc_out_if         out_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned waiting_cnt_o
);

  // Shadow of the compressor state
  logic        in_tail;
  logic        grp_active;
  logic        cur_zero;
  int unsigned cur_count;
  logic        head_zero;
  logic [2:0]  head_len;
  logic [7:0]  lit_buf [zrbc_pkg::LitDepth];
  int unsigned lit_cnt;

  zrbc_pkg::item_t expected_items [$];
  int unsigned     mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  // Zero run codes count-1, literal run codes (8-count) mod 8
  function automatic logic [2:0] run_code(input logic zero, input int unsigned count);
    return zero ? 3'(count - 1) : 3'(8 - count);
  endfunction

  // Queue the opcode and the buffered literals, then close the group
  task automatic emit_group(input logic tail_zero, input logic [2:0] tail_len);
    zrbc_pkg::item_t it;
    it = '0;
    it.kind        = zrbc_pkg::KindOpcode;
    it.first_zero  = head_zero;
    it.first_len   = head_len;
    it.second_zero = tail_zero;
    it.second_len  = tail_len;
    expected_items.push_back(it);
    for (int unsigned i = 0; i < lit_cnt; i++) begin
      it      = '0;
      it.kind = zrbc_pkg::KindLiteral;
      it.lit  = lit_buf[i];
      expected_items.push_back(it);
    end
    grp_active = 1'b0;
    in_tail    = 1'b0;
    cur_count  = 0;
    lit_cnt    = 0;
  endtask

  // Finish the open run: save it as head part, or finish the group
  task automatic close_run();
    if (!in_tail) begin
      head_zero = cur_zero;
      head_len  = run_code(cur_zero, cur_count);
      in_tail   = 1'b1;
      cur_count = 0;
    end else begin
      emit_group(cur_zero, run_code(cur_zero, cur_count));
    end
  endtask

  // Advance the shadow state by one input byte and queue what it produces
  task automatic compress_byte(input logic [7:0] b, input logic lst);
    int unsigned     prev_size;
    zrbc_pkg::item_t tail_item;
    logic            z;
    z         = (b == 8'h00);
    prev_size = expected_items.size();
    if (grp_active && cur_count > 0 && cur_zero != z) close_run();
    if (grp_active && cur_count > 0) begin
      cur_count++;
    end else begin
      if (!grp_active) begin
        grp_active = 1'b1;
        in_tail    = 1'b0;
        lit_cnt    = 0;
      end
      cur_zero  = z;
      cur_count = 1;
    end
    if (!z && lit_cnt < zrbc_pkg::LitDepth) begin
      lit_buf[lit_cnt] = b;
      lit_cnt++;
    end
    if (cur_count >= zrbc_pkg::MaxRun) close_run();
    // End of stream: flush, marking a missing second part as zero of length 0
    if (lst && grp_active) begin
      if (cur_count > 0 && in_tail) begin
        close_run();
      end else begin
        if (cur_count > 0) close_run();
        emit_group(1'b1, 3'd0);
      end
    end
    if (lst && expected_items.size() > prev_size) begin
      tail_item           = expected_items.pop_back();
      tail_item.last_item = 1'b1;
      expected_items.push_back(tail_item);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    zrbc_pkg::item_t want;
    if (!rst_ni) begin
      in_tail    = 1'b0;
      grp_active = 1'b0;
      cur_zero   = 1'b0;
      cur_count  = 0;
      head_zero  = 1'b0;
      head_len   = 3'd0;
      lit_cnt    = 0;
      expected_items.delete();
      waiting_cnt_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        compress_byte(in_mon.data_byte, in_mon.last_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_items.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none, actual kind %0b lit %0h",
                   $time, out_mon.item_kind, out_mon.literal_value);
        end else begin
          want = expected_items.pop_front();
          check_field("item_kind", 8'(want.kind), 8'(out_mon.item_kind));
          check_field("literal_value", want.lit, out_mon.literal_value);
          check_field("first_zero_run", 8'(want.first_zero), 8'(out_mon.first_zero_run));
          check_field("first_length", 8'(want.first_len), 8'(out_mon.first_length));
          check_field("second_zero_run", 8'(want.second_zero),
                      8'(out_mon.second_zero_run));
          check_field("second_length", 8'(want.second_len), 8'(out_mon.second_length));
          check_field("final_item", 8'(want.last_item), 8'(out_mon.final_item));
        end
      end
      waiting_cnt_o <= expected_items.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ByteTarget = 280;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;

  logic        clk;
  logic        rst_n;
  logic        idle_en;
  int unsigned bytes_sent;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned waiting_cnt;
  int unsigned stall_left;

  // {last, byte}: lone bytes, a pair, a full literal part then one more, a full zero part, two zeros then a literal
  logic [8:0] directed_bytes [24] = '{
    9'h100, 9'h1FF,
    9'h001, 9'h100,
    9'h080, 9'h07F, 9'h055, 9'h0AA, 9'h001, 9'h0FE, 9'h040, 9'h002, 9'h110,
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h100,
    9'h000, 9'h000, 9'h15A
  };

  zrbc_in_if  in_ch ();
  zrbc_out_if out_ch ();

  zero_run_byte_compressor_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  zrbc_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .waiting_cnt_o (waiting_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: stall in random bursts while idling is enabled
  initial begin
    stall_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Present one byte, hold it until the transaction completes
  task automatic push_byte(input logic [7:0] b, input logic lst);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Build a stream from zero and literal runs, with some odd bytes mixed in
  task automatic send_stream(input int unsigned n_bytes);
    logic        zero_run;
    int unsigned left;
    logic [7:0]  b;
    left     = 0;
    zero_run = 1'b0;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if (left == 0) begin
        zero_run = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: begin
            left = 8;
          end
          1: begin
            left = $urandom_range(9, 16);
          end
          default: begin
            left = $urandom_range(1, 7);
          end
        endcase
      end
      b = zero_run ? 8'h00 : 8'($urandom_range(1, 255));
      if ($urandom_range(0, 15) == 0) b = 8'($urandom_range(0, 255));
      push_byte(b, i == n_bytes - 1);
      left--;
    end
  endtask

  initial begin
    int unsigned n;
    bytes_sent      = 0;
    idle_en         = 1'b1;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

    // Random streams: idle, then a quiet stretch, idle again, quiet to the end
    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= 220) idle_en = 1'b0;
      else idle_en = !(bytes_sent >= 110 && bytes_sent < 150);
      n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      send_stream(n);
    end
    in_ch.valid <= 1'b0;
    idle_en = 1'b0;

    // Drain outstanding results
    @(posedge clk);
    while (waiting_cnt != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_cnt == 0 && waiting_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
